// File: rtl/wot_pkg.sv
// ----------------------------------------------------------------------------
// wot_pkg
// Shared widths, codes, types and helper functions of the wheel odometry
// tracker: field widths, fixed-point formats, CORDIC constants and tables.
// ----------------------------------------------------------------------------
package wot_pkg;

   // fractional bits of the sine and cosine values
   localparam int TRIG_FRAC_BITS = 15;

   // interface field widths
   localparam int POS_W      = 32;
   localparam int CNT_W      = 32;
   localparam int DPT_W      = 20;
   localparam int OFF_W      = 17;
   localparam int YAW_W      = 16;
   localparam int PITCH_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // distance per tick is Q16
   localparam int DIST_FRAC_BITS = 16;

   // datapath widths
   localparam int D_W     = 37;               // distance and partial steps
   localparam int A_W     = 38;               // multiplier a operand
   localparam int LO_W    = 19;               // low chunk of a
   localparam int HI_W    = A_W - LO_W;       // signed high chunk of a
   localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
   localparam int XY_W    = TRIG_FRAC_BITS + 3;
   localparam int MUL_B_W = (TRIG_W > DPT_W + 1) ? TRIG_W : DPT_W + 1;
   localparam int PP_W    = LO_W + 1 + MUL_B_W;
   localparam int P_W     = A_W + MUL_B_W;
   localparam int SUM_W   = D_W + 2;

   // angle handling
   localparam int ANG_W          = 18;
   localparam int Z_W            = 32;
   localparam int ANG_SCALE_BITS = 16;
   localparam int CORDIC_STEPS   = 24;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);

   localparam logic signed [ANG_W-1:0] FULL_A         = ANG_W'(36000);
   localparam logic signed [ANG_W-1:0] HALF_A         = ANG_W'(18000);
   localparam logic signed [ANG_W-1:0] NEG_HALF_A     = -HALF_A;
   localparam logic signed [ANG_W-1:0] QUARTER_A      = ANG_W'(9000);
   localparam logic signed [ANG_W-1:0] NEG_QUARTER_A  = -QUARTER_A;

   // cordic gain, Q30, brought to the trig format
   localparam longint GAIN_Q30  = 652032874;
   localparam longint CORDIC_X0 =
      (GAIN_Q30 + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);

   localparam logic signed [XY_W-1:0] ONE_XY     = XY_W'(longint'(1) << TRIG_FRAC_BITS);
   localparam logic signed [XY_W-1:0] NEG_ONE_XY = -ONE_XY;

   localparam logic signed [P_W-1:0] HALF_DIST = P_W'(longint'(1) << (DIST_FRAC_BITS - 1));
   localparam logic signed [P_W-1:0] HALF_TRIG = P_W'(longint'(1) << (TRIG_FRAC_BITS - 1));

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(longint'(2147483647));
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   localparam logic [DPT_W-1:0] DPT_RESET = DPT_W'(65536);

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X  = 2'd0,
      CSR_START_Y  = 2'd1,
      CSR_DIST_PER = 2'd2,
      CSR_YAW_OFF  = 2'd3
   } csr_index_type;

   // rounding shift of the multiplier
   typedef enum logic {
      RND_DIST,
      RND_TRIG
   } rnd_sel_type;

   typedef enum logic [1:0] {
      MP_IDLE,
      MP_HI,
      MP_ACC,
      MP_RND
   } mul_phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_REDUCE,
      CS_FOLD,
      CS_ITER,
      CS_CLAMP
   } cor_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YAW,
      ST_PITCH,
      ST_MX,
      ST_MY,
      ST_UPD,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // saturate to the signed position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[POS_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // clamp a cordic result to plus or minus one
   function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > ONE_XY) begin
         r = ONE_XY[TRIG_W-1:0];
      end else if (v < NEG_ONE_XY) begin
         r = NEG_ONE_XY[TRIG_W-1:0];
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

   // atan(2^-i) in 1/65536 hundredth degree
   function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] r;
      unique case (i)
         STEP_W'(0):  r = Z_W'(294912000);
         STEP_W'(1):  r = Z_W'(174096719);
         STEP_W'(2):  r = Z_W'(91987925);
         STEP_W'(3):  r = Z_W'(46694507);
         STEP_W'(4):  r = Z_W'(23437865);
         STEP_W'(5):  r = Z_W'(11730358);
         STEP_W'(6):  r = Z_W'(5866610);
         STEP_W'(7):  r = Z_W'(2933484);
         STEP_W'(8):  r = Z_W'(1466764);
         STEP_W'(9):  r = Z_W'(733385);
         STEP_W'(10): r = Z_W'(366693);
         STEP_W'(11): r = Z_W'(183347);
         STEP_W'(12): r = Z_W'(91673);
         STEP_W'(13): r = Z_W'(45837);
         STEP_W'(14): r = Z_W'(22918);
         STEP_W'(15): r = Z_W'(11459);
         STEP_W'(16): r = Z_W'(5730);
         STEP_W'(17): r = Z_W'(2865);
         STEP_W'(18): r = Z_W'(1432);
         STEP_W'(19): r = Z_W'(716);
         STEP_W'(20): r = Z_W'(358);
         STEP_W'(21): r = Z_W'(179);
         STEP_W'(22): r = Z_W'(90);
         STEP_W'(23): r = Z_W'(45);
         default:     r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/wot_mul.sv
// ----------------------------------------------------------------------------
// wot_mul
// Shared two-pass multiplier with rounding shift: the a operand is split into
// a low and a high chunk, each multiplied in its own cycle, then the sum is
// rounded and shifted right by the distance or trig fraction bits.
// ----------------------------------------------------------------------------
module wot_mul
   import wot_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [A_W-1:0]      a,
   input  logic signed [MUL_B_W-1:0]  b,
   input  rnd_sel_type                rnd_sel,
   output unit_status_type            status,
   output logic signed [D_W-1:0]      result
);

   mul_phase_type               phase_ff, phase_in;
   logic                        done_ff, done_in;
   logic signed [PP_W-1:0]      pp_ff, pp_in;
   logic signed [HI_W-1:0]      ahi_ff, ahi_in;
   logic signed [MUL_B_W-1:0]   b_ff, b_in;
   rnd_sel_type                 sel_ff, sel_in;
   logic signed [P_W-1:0]       acc_ff, acc_in;
   logic signed [D_W-1:0]       res_ff, res_in;

   logic signed [PP_W-1:0]      pp_lo;
   logic signed [PP_W-1:0]      pp_hi;
   logic signed [P_W-1:0]       pp_ext;
   logic signed [P_W-1:0]       rsum;
   logic signed [P_W-1:0]       rshift;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      ahi_ff <= ahi_in;
      b_ff   <= b_in;
      sel_ff <= sel_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      pp_in    = pp_ff;
      ahi_in   = ahi_ff;
      b_in     = b_ff;
      sel_in   = sel_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;

      // low chunk is unsigned, high chunk carries the sign
      pp_lo  = $signed({1'b0, a[LO_W-1:0]}) * b;
      pp_hi  = ahi_ff * b_ff;
      pp_ext = P_W'(pp_ff);
      rsum   = acc_ff + ((sel_ff == RND_TRIG) ? HALF_TRIG : HALF_DIST);
      rshift = (sel_ff == RND_TRIG) ? (rsum >>> TRIG_FRAC_BITS) : (rsum >>> DIST_FRAC_BITS);

      unique case (phase_ff)
         MP_IDLE: begin
            if (start) begin
               pp_in    = pp_lo;
               ahi_in   = a[A_W-1:LO_W];
               b_in     = b;
               sel_in   = rnd_sel;
               phase_in = MP_HI;
            end
         end
         MP_HI: begin
            acc_in   = pp_ext;
            pp_in    = pp_hi;
            phase_in = MP_ACC;
         end
         MP_ACC: begin
            acc_in   = acc_ff + (pp_ext <<< LO_W);
            phase_in = MP_RND;
         end
         MP_RND: begin
            res_in   = rshift[D_W-1:0];
            done_in  = 1'b1;
            phase_in = MP_IDLE;
         end
         default: begin
            phase_in = MP_IDLE;
         end
      endcase
   end

   assign status.busy = (phase_ff != MP_IDLE);
   assign status.done = done_ff;
   assign result      = res_ff;

endmodule

// File: rtl/wot_cordic.sv
// ----------------------------------------------------------------------------
// wot_cordic
// Iterative rotation-mode CORDIC: reduces an angle in hundredths of a degree
// into the half turn, folds it into the right half plane and runs one
// micro-rotation per cycle, then clamps the cosine and sine to unit range.
// ----------------------------------------------------------------------------
module wot_cordic
   import wot_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ANG_W-1:0]   angle,
   output unit_status_type           status,
   output logic signed [TRIG_W-1:0]  cos_q,
   output logic signed [TRIG_W-1:0]  sin_q
);

   cor_state_type              state_ff, state_in;
   logic                       done_ff, done_in;
   logic signed [ANG_W-1:0]    r_ff, r_in;
   logic                       neg_ff, neg_in;
   logic signed [XY_W-1:0]     x_ff, x_in;
   logic signed [XY_W-1:0]     y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic [STEP_W-1:0]          i_ff, i_in;
   logic signed [TRIG_W-1:0]   cos_ff, cos_in;
   logic signed [TRIG_W-1:0]   sin_ff, sin_in;

   logic signed [XY_W-1:0]     dx;
   logic signed [XY_W-1:0]     dy;
   logic signed [Z_W-1:0]      atan_i;
   logic signed [ANG_W-1:0]    r_fold;
   logic                       fold_neg;
   logic signed [TRIG_W-1:0]   x_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      i_ff   <= i_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      r_in     = r_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;

      dx      = y_ff >>> i_ff;
      dy      = x_ff >>> i_ff;
      atan_i  = atan_step(i_ff);
      x_clamp = clamp_unit(x_ff);

      // fold into the right half plane, cosine changes sign
      priority if (r_ff > QUARTER_A) begin
         r_fold   = HALF_A - r_ff;
         fold_neg = 1'b1;
      end else if (r_ff < NEG_QUARTER_A) begin
         r_fold   = NEG_HALF_A - r_ff;
         fold_neg = 1'b1;
      end else begin
         r_fold   = r_ff;
         fold_neg = 1'b0;
      end

      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               r_in     = angle;
               state_in = CS_REDUCE;
            end
         end
         CS_REDUCE: begin
            // one turn per cycle until inside [-half, half)
            priority if (r_ff >= HALF_A) begin
               r_in = r_ff - FULL_A;
            end else if (r_ff < NEG_HALF_A) begin
               r_in = r_ff + FULL_A;
            end else begin
               state_in = CS_FOLD;
            end
         end
         CS_FOLD: begin
            neg_in   = fold_neg;
            z_in     = Z_W'(r_fold) <<< ANG_SCALE_BITS;
            x_in     = XY_W'(CORDIC_X0);
            y_in     = '0;
            i_in     = '0;
            state_in = CS_ITER;
         end
         CS_ITER: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_i;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_i;
            end
            if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = CS_CLAMP;
            end else begin
               i_in = i_ff + STEP_W'(1);
            end
         end
         CS_CLAMP: begin
            cos_in   = neg_ff ? -x_clamp : x_clamp;
            sin_in   = clamp_unit(y_ff);
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != CS_IDLE);
   assign status.done = done_ff;
   assign cos_q       = cos_ff;
   assign sin_q       = sin_ff;

endmodule

// File: rtl/wheel_odometry_tracker_core.sv
// ----------------------------------------------------------------------------
// wheel_odometry_tracker_core
// Dead-reckoning position tracker: encoder count delta scaled to distance,
// rotated by heading, scaled by cosine of pitch and accumulated into X and Y.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time and gives one response
// transaction with the start position plus the saturated displacement. After
// a request is taken req_stall stays high until the sequencer is back in idle;
// almost all of that time is the shared CORDIC unit, which runs 24
// micro-rotations for the heading and then again for the pitch. Angle
// reduction removes whole turns from heading plus offset until it lies inside
// the half turn; the pitch already lies inside it. The shared two-pass
// multiplier works on the distance and the heading products while the CORDIC
// is busy; the two pitch products, the displacement update and the output
// stage follow. The response sits in an output register, so a stalled
// response does not hold up taking the next request, though that request
// waits in the output stage until the response is taken. Configuration
// writes are always taken (csr_ready is tied high).
// ----------------------------------------------------------------------------
module wheel_odometry_tracker_core
   import wot_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_moving_forward,
   input  logic signed [CNT_W-1:0]      req_encoder_count,
   input  logic signed [YAW_W-1:0]      req_yaw_hundredths,
   input  logic signed [PITCH_W-1:0]    req_pitch_hundredths,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POS_W-1:0]      rsp_x_pos,
   output logic signed [POS_W-1:0]      rsp_y_pos,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   seq_state_type               state_ff, state_in;
   logic                        second_ff, second_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic signed [POS_W-1:0]     start_x_ff, start_x_in;
   logic signed [POS_W-1:0]     start_y_ff, start_y_in;
   logic [DPT_W-1:0]            dpt_ff, dpt_in;
   logic signed [OFF_W-1:0]     yaw_off_ff, yaw_off_in;

   logic signed [POS_W-1:0]     disp_x_ff, disp_x_in;
   logic signed [POS_W-1:0]     disp_y_ff, disp_y_in;
   logic signed [CNT_W-1:0]     last_count_ff, last_count_in;

   logic                        fwd_ff, fwd_in;
   logic signed [PITCH_W-1:0]   pitch_ff, pitch_in;
   logic signed [D_W-1:0]       d_ff, d_in;
   logic signed [TRIG_W-1:0]    sy_ff, sy_in;
   logic signed [TRIG_W-1:0]    cp_ff, cp_in;
   logic signed [D_W-1:0]       tx_ff, tx_in;
   logic signed [D_W-1:0]       ty_ff, ty_in;
   logic signed [D_W-1:0]       stepx_ff, stepx_in;
   logic signed [D_W-1:0]       stepy_ff, stepy_in;
   logic signed [POS_W-1:0]     rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0]     rsp_y_ff, rsp_y_in;

   logic                        mul_start;
   logic signed [A_W-1:0]       mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   rnd_sel_type                 mul_sel;
   unit_status_type             mul_st;
   logic signed [D_W-1:0]       mul_result;

   logic                        cor_start;
   logic signed [ANG_W-1:0]     cor_angle;
   unit_status_type             cor_st;
   logic signed [TRIG_W-1:0]    cor_cos;
   logic signed [TRIG_W-1:0]    cor_sin;

   logic signed [CNT_W-1:0]     delta;
   logic signed [SUM_W-1:0]     term_x;
   logic signed [SUM_W-1:0]     term_y;

   wot_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .rnd_sel (mul_sel),
      .status  (mul_st),
      .result  (mul_result)
   );

   wot_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .angle  (cor_angle),
      .status (cor_st),
      .cos_q  (cor_cos),
      .sin_q  (cor_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         dpt_ff        <= DPT_RESET;
         yaw_off_ff    <= '0;
         disp_x_ff     <= '0;
         disp_y_ff     <= '0;
         last_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         dpt_ff        <= dpt_in;
         yaw_off_ff    <= yaw_off_in;
         disp_x_ff     <= disp_x_in;
         disp_y_ff     <= disp_y_in;
         last_count_ff <= last_count_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff   <= fwd_in;
      pitch_ff <= pitch_in;
      d_ff     <= d_in;
      sy_ff    <= sy_in;
      cp_ff    <= cp_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      stepx_ff <= stepx_in;
      stepy_ff <= stepy_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   // configuration registers
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      dpt_in     = dpt_ff;
      yaw_off_in = yaw_off_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_X:  start_x_in = csr_data[POS_W-1:0];
            CSR_START_Y:  start_y_in = csr_data[POS_W-1:0];
            CSR_DIST_PER: dpt_in     = csr_data[DPT_W-1:0];
            CSR_YAW_OFF:  yaw_off_in = csr_data[OFF_W-1:0];
            default:      ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      disp_x_in     = disp_x_ff;
      disp_y_in     = disp_y_ff;
      last_count_in = last_count_ff;
      fwd_in        = fwd_ff;
      pitch_in      = pitch_ff;
      d_in          = d_ff;
      sy_in         = sy_ff;
      cp_in         = cp_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      stepx_in      = stepx_ff;
      stepy_in      = stepy_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_sel   = RND_TRIG;
      cor_start = 1'b0;
      cor_angle = '0;

      delta  = req_encoder_count - last_count_ff;
      term_x = fwd_ff ? SUM_W'(stepx_ff) : -SUM_W'(stepx_ff);
      term_y = fwd_ff ? SUM_W'(stepy_ff) : -SUM_W'(stepy_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // distance product and heading rotation start together
               last_count_in = req_encoder_count;
               fwd_in        = req_moving_forward;
               pitch_in      = req_pitch_hundredths;
               mul_start     = 1'b1;
               mul_a         = A_W'(delta);
               mul_b         = MUL_B_W'(dpt_ff);
               mul_sel       = RND_DIST;
               cor_start     = 1'b1;
               cor_angle     = ANG_W'(req_yaw_hundredths) + ANG_W'(yaw_off_ff);
               state_in      = ST_YAW;
            end
         end
         ST_YAW: begin
            if (mul_st.done) begin
               d_in = mul_result;
            end
            if (cor_st.done) begin
               sy_in     = cor_sin;
               cor_start = 1'b1;
               cor_angle = ANG_W'(pitch_ff);
               mul_start = 1'b1;
               mul_a     = A_W'(d_ff);
               mul_b     = MUL_B_W'(cor_cos);
               second_in = 1'b0;
               state_in  = ST_PITCH;
            end
         end
         ST_PITCH: begin
            // heading products run while the pitch rotation is busy
            if (mul_st.done) begin
               if (!second_ff) begin
                  tx_in     = mul_result;
                  mul_start = 1'b1;
                  mul_a     = A_W'(d_ff);
                  mul_b     = MUL_B_W'(sy_ff);
                  second_in = 1'b1;
               end else begin
                  ty_in = mul_result;
               end
            end
            if (cor_st.done) begin
               cp_in     = cor_cos;
               mul_start = 1'b1;
               mul_a     = A_W'(tx_ff);
               mul_b     = MUL_B_W'(cor_cos);
               state_in  = ST_MX;
            end
         end
         ST_MX: begin
            if (mul_st.done) begin
               stepx_in  = mul_result;
               mul_start = 1'b1;
               mul_a     = A_W'(ty_ff);
               mul_b     = MUL_B_W'(cp_ff);
               state_in  = ST_MY;
            end
         end
         ST_MY: begin
            if (mul_st.done) begin
               stepy_in = mul_result;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            disp_x_in = sat_pos(SUM_W'(disp_x_ff) + term_x);
            disp_y_in = sat_pos(SUM_W'(disp_y_ff) + term_y);
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_x_in     = sat_pos(SUM_W'(start_x_ff) + SUM_W'(disp_x_ff));
               rsp_y_in     = sat_pos(SUM_W'(start_y_ff) + SUM_W'(disp_y_ff));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_pos = rsp_x_ff;
   assign rsp_y_pos = rsp_y_ff;
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   // distance product is in before the heading rotation finishes
   a_dist_before_yaw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YAW && cor_st.done) |-> (!mul_st.busy && !mul_st.done))
      else $error("distance product still pending at heading result");

   // both heading products are in before the pitch rotation finishes
   a_products_before_pitch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PITCH && cor_st.done) |-> (second_ff && !mul_st.busy && !mul_st.done))
      else $error("heading products still pending at pitch result");

   a_cordic_done_place: assert property (@(posedge clock) disable iff (reset)
      cor_st.done |-> (state_ff == ST_YAW || state_ff == ST_PITCH))
      else $error("cordic result outside the rotation states");

   a_out_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !(rsp_valid_ff && rsp_stall)) |=>
         (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("output stage did not hand over its transaction");
`endif

endmodule
